### rtl/core/oase_pkg.sv
// ----------------------------------------------------------------------------
// oase_pkg: shared definitions for the ordered array store engine
// Operation codes, status codes, field widths, default sizes and chain shift commands.
// ----------------------------------------------------------------------------
package oase_pkg;

    localparam int DEPTH_DEFAULT      = 32;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int MODE_W   = 4;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 6;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int OUT_W    = 32;

    localparam logic [MODE_W-1:0] MODE_INS_POS   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INS_END   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 4'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_END   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_REVERSE   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SUM       = 4'd7;
    localparam logic [MODE_W-1:0] MODE_SEARCH    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_DUMP_FWD  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_DUMP_REV  = 4'd10;
    localparam logic [MODE_W-1:0] MODE_DUMP_ODD  = 4'd11;
    localparam logic [MODE_W-1:0] MODE_DUMP_SIGN = 4'd12;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // chain shift commands
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } t_cmd;

endpackage

### rtl/core/ordered_array_store_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_store_engine: ordered array of signed words with a count
// Insert/delete/reverse/sum/search/dump over a chain of storage cells.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | i_valid, o_ready, i_mode, i_value, i_position
// out     | output    | o_valid, i_ready, o_status .. o_last
//
// Insert/delete shift the cells at and above the position in the accept cycle;
// the result follows in the next cycle, and no new command is taken until it is accepted.
// Reverse: repeated rotates, the window shrinking by one after each, then a result.
// Sum/search walk one entry a cycle; forward/reverse dumps give one result a
// cycle while the receiver is ready, and odd/sign dumps scan up to twice.
// One transaction at a time; reset clears the count, entries are left as is.
// A stalled output holds the walk; ready drops while a command is busy.
// ----------------------------------------------------------------------------
module ordered_array_store_engine #(
    parameter int DEPTH      = oase_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = oase_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_mode,
    input  logic signed [31:0] i_value,
    input  logic [5:0]  i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic signed [31:0] o_element,
    output logic [4:0]  o_index,
    output logic signed [31:0] o_total,
    output logic [5:0]  o_count,
    output logic        o_group,
    output logic        o_last
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_REV, S_WALK, S_OUT
    } t_state;

    t_state                r_state;
    logic [3:0]            r_mode;
    logic [DATA_WIDTH-1:0] r_key;
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         r_i;      // walk index
    logic                  r_g;      // partition pass
    logic [CW-1:0]         r_lo, r_hi; // reverse window [lo, hi)
    logic [DATA_WIDTH-1:0] r_sum;
    logic [CW-1:0]         r_emitted; // partition results sent so far

    logic [2:0]  r_status;
    logic [31:0] r_element, r_total;
    logic [4:0]  r_index;
    logic        r_group, r_last;

    oase_pkg::t_cmd        w_cmd;
    logic [CW-1:0]         w_pos;
    logic [DATA_WIDTH-1:0] w_cell [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd;
    logic                  w_acc;
    logic                  w_cls;

    assign w_acc   = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    // read of the walked entry (fixed mux over cell outputs)
    assign w_rd  = w_cell[r_i[AW-1:0]];
    assign w_cls = (r_mode == oase_pkg::MODE_DUMP_ODD) ? w_rd[0] : w_rd[DATA_WIDTH-1];

    // legality of insert/delete commands
    logic w_ins, w_del, w_ok;
    logic [CW-1:0] w_ipos;
    logic [2:0] w_st;
    always_comb begin
        w_ins  = (i_mode <= oase_pkg::MODE_INS_END);
        w_del  = (i_mode >= oase_pkg::MODE_DEL_POS) && (i_mode <= oase_pkg::MODE_DEL_END);
        w_ipos = '0;
        w_st   = oase_pkg::ST_OK;
        case (i_mode)
            oase_pkg::MODE_INS_POS:  w_ipos = CW'(i_position);
            oase_pkg::MODE_INS_END:  w_ipos = r_cnt;
            oase_pkg::MODE_DEL_POS:  w_ipos = CW'(i_position);
            oase_pkg::MODE_DEL_END:  w_ipos = r_cnt - CW'(1);
            default:                 w_ipos = '0;
        endcase
        if (w_ins) begin
            if (r_cnt >= CW'(DEPTH)) w_st = oase_pkg::ST_FULL;
            else if ({1'b0, i_position} > 7'(r_cnt) && i_mode == oase_pkg::MODE_INS_POS)
                w_st = oase_pkg::ST_BAD_POS;
        end else if (w_del) begin
            if (r_cnt == '0) w_st = oase_pkg::ST_EMPTY;
            else if ({1'b0, i_position} >= 7'(r_cnt) && i_mode == oase_pkg::MODE_DEL_POS)
                w_st = oase_pkg::ST_BAD_POS;
        end
        w_ok = (w_st == oase_pkg::ST_OK);
    end

    always_comb begin
        w_cmd = oase_pkg::CMD_HOLD;
        w_pos = w_ipos;
        if (r_state == S_IDLE && w_acc && w_ok && w_ins) w_cmd = oase_pkg::CMD_INSERT;
        else if (r_state == S_IDLE && w_acc && w_ok && w_del) w_cmd = oase_pkg::CMD_DELETE;
        else if (r_state == S_REV && (r_lo + CW'(1) < r_hi)) w_cmd = oase_pkg::CMD_ROTATE;
    end

    // Reverse by repeated rotate: each cycle rotates window [lo,hi) left, so
    // the bottom word lands at hi-1; then hi shrinks by one.
    genvar c;
    generate
        for (c = 0; c < DEPTH; c++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_l, w_r;
            if (c == 0) begin : g_l0
                assign w_l = '0;
            end else begin : g_ln
                assign w_l = w_cell[c-1];
            end
            if (c == DEPTH - 1) begin : g_rt
                assign w_r = '0;
            end else begin : g_rn
                assign w_r = w_cell[c+1];
            end
            oase_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                .i_clk      (i_clk),
                .i_cmd      (w_cmd),
                .i_at_pos   (CW'(c) == w_pos),
                .i_above    (CW'(c) > w_pos),
                .i_in_range ((CW'(c) >= r_lo) && (CW'(c) < r_hi)),
                .i_word     (i_value[DATA_WIDTH-1:0]),
                .i_left     (w_l),
                .i_right    (w_r),
                .i_top      (w_cell[r_lo[AW-1:0]]),
                .i_is_top   (CW'(c) + CW'(1) == r_hi),
                .o_word     (w_cell[c])
            );
        end
    endgenerate

    // note on rotate: the window shifts down (cell takes right), top takes
    // old bottom; that is a rotate-left. Repeating with hi shrinking reverses.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_mode    <= i_mode;
                        r_key     <= i_value[DATA_WIDTH-1:0];
                        r_i       <= '0;
                        r_g       <= 1'b0;
                        r_sum     <= '0;
                        r_emitted <= '0;
                        r_status  <= w_st;
                        r_element <= '0;
                        r_index   <= '0;
                        r_total   <= '0;
                        r_group   <= 1'b0;
                        r_last    <= 1'b1;
                        r_lo      <= '0;
                        r_hi      <= r_cnt;
                        if (w_ok && w_ins) r_cnt <= r_cnt + CW'(1);
                        if (w_ok && w_del) r_cnt <= r_cnt - CW'(1);
                        if (i_mode == oase_pkg::MODE_REVERSE) begin
                            r_state <= S_REV;
                        end else if (i_mode >= oase_pkg::MODE_SUM &&
                                     i_mode <= oase_pkg::MODE_DUMP_SIGN) begin
                            if (i_mode >= oase_pkg::MODE_DUMP_FWD && r_cnt == '0) begin
                                r_status <= oase_pkg::ST_EMPTY;
                                o_valid  <= 1'b1;
                                r_state  <= S_OUT;
                            end else begin
                                r_i     <= (i_mode == oase_pkg::MODE_DUMP_REV) ?
                                           r_cnt - CW'(1) : '0;
                                r_state <= S_WALK;
                            end
                        end else begin
                            o_valid <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_REV: begin
                    // rotate [lo,hi) left puts old lo at hi-1; continue
                    // with [lo,hi-1) until window < 2. Result reverses.
                    if (r_lo + CW'(1) < r_hi) begin
                        r_hi <= r_hi - CW'(1);
                    end else begin
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_WALK: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b0;
                        case (r_mode)
                            oase_pkg::MODE_SUM: begin
                                if (r_i == r_cnt) begin
                                    r_total <= 32'(r_sum);
                                    o_valid <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_sum <= r_sum + w_rd;
                                    r_i   <= r_i + CW'(1);
                                end
                            end
                            oase_pkg::MODE_SEARCH: begin
                                if (r_i == r_cnt) begin
                                    r_status <= oase_pkg::ST_NOT_FOUND;
                                    o_valid  <= 1'b1;
                                    r_state  <= S_OUT;
                                end else if (w_rd == r_key) begin
                                    r_index <= 5'(r_i);
                                    o_valid <= 1'b1;
                                    r_state <= S_OUT;
                                end else begin
                                    r_i <= r_i + CW'(1);
                                end
                            end
                            oase_pkg::MODE_DUMP_FWD, oase_pkg::MODE_DUMP_REV: begin
                                r_element <= 32'(signed'(w_rd));
                                r_index   <= 5'(r_i);
                                o_valid   <= 1'b1;
                                if (r_mode == oase_pkg::MODE_DUMP_FWD) begin
                                    r_last <= (r_i + CW'(1) == r_cnt);
                                    if (r_i + CW'(1) == r_cnt) r_state <= S_OUT;
                                    r_i <= r_i + CW'(1);
                                end else begin
                                    r_last <= (r_i == '0);
                                    if (r_i == '0) r_state <= S_OUT;
                                    r_i <= r_i - CW'(1);
                                end
                            end
                            default: begin
                                // partition dumps: up to two passes; each entry goes
                                // out once, so the n-th transaction is last
                                if (w_cls == r_g) begin
                                    r_element <= 32'(signed'(w_rd));
                                    r_index   <= 5'(r_i);
                                    r_group   <= r_g;
                                    o_valid   <= 1'b1;
                                    r_last    <= (r_emitted + CW'(1) == r_cnt);
                                    r_emitted <= r_emitted + CW'(1);
                                    if (r_emitted + CW'(1) == r_cnt) r_state <= S_OUT;
                                end
                                if (r_i + CW'(1) == r_cnt) begin
                                    r_i <= '0;
                                    r_g <= 1'b1;
                                end else begin
                                    r_i <= r_i + CW'(1);
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_index   = r_index;
    assign o_total   = r_total;
    assign o_count   = 6'(r_cnt);
    assign o_group   = r_group;
    assign o_last    = r_last;

    // assertions
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("count beyond depth");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_state == S_OUT && i_ready) |-> o_last)
        else $error("final transaction without last");
endmodule

### rtl/core/oase_cell.sv
// ----------------------------------------------------------------------------
// oase_cell: one storage slot of the array chain
// Holds one word; on command takes the new word, its left or right neighbor, or the rotate wrap value.
// ----------------------------------------------------------------------------
module oase_cell #(
    parameter int DATA_WIDTH = oase_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  oase_pkg::t_cmd        i_cmd,
    input  logic                  i_at_pos,   // this cell is the insert or delete point
    input  logic                  i_above,    // this cell lies above the point
    input  logic                  i_in_range, // cell inside the rotate window
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_left,     // cell index - 1
    input  logic [DATA_WIDTH-1:0] i_right,    // cell index + 1
    input  logic [DATA_WIDTH-1:0] i_top,      // rotate wrap value
    input  logic                  i_is_top,
    output logic [DATA_WIDTH-1:0] o_word
);
    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd)
            oase_pkg::CMD_INSERT: begin
                if (i_at_pos) n_word = i_word;
                else if (i_above) n_word = i_left;
            end
            oase_pkg::CMD_DELETE: begin
                if (i_at_pos || i_above) n_word = i_right;
            end
            oase_pkg::CMD_ROTATE: begin
                // rotate window left by one: top takes the bottom value
                if (i_in_range) n_word = i_is_top ? i_top : i_right;
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
endmodule

### tb/oase_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oase_checker: scoreboard for the ordered array store engine
// Mirrors the array on every accepted command and compares each result.
// ----------------------------------------------------------------------------
module oase_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic [3:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_position,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [2:0]         i_status,
    input  logic signed [31:0] i_element,
    input  logic [4:0]         i_index,
    input  logic signed [31:0] i_total,
    input  logic [5:0]         i_count,
    input  logic               i_group,
    input  logic               i_last,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_commands,
    output int                 o_results
);

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] element;
        logic [4:0]  index;
        logic [31:0] total;
        logic [5:0]  count;
        logic        group;
        logic        last;
    } t_result;

    logic [31:0] shadow [32];
    int          shadow_cnt;
    t_result     expected_q[$];

    assign o_pending = expected_q.size();

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        o_errors++;
    endtask

    function automatic t_result mk(logic [2:0] st, logic [31:0] el, int idx,
                                   logic [31:0] tot, logic grp, logic lst);
        t_result r;
        r.status  = st;
        r.element = el;
        r.index   = idx[4:0];
        r.total   = tot;
        r.count   = shadow_cnt[5:0];
        r.group   = grp;
        r.last    = lst;
        return r;
    endfunction

    task automatic predict_command(input logic [3:0] mode, input logic [31:0] val,
                                   input int pos);
        logic [2:0]  st;
        logic [31:0] acc;
        logic [31:0] tmp;
        logic        cls;
        int          k;
        int          hit;
        st = oase_pkg::ST_OK;
        // resolve front/end forms into positional insert/delete
        if (mode == oase_pkg::MODE_INS_FRONT) pos = 0;
        if (mode == oase_pkg::MODE_INS_END) pos = shadow_cnt;
        if (mode == oase_pkg::MODE_DEL_FRONT) pos = 0;
        if (mode == oase_pkg::MODE_DEL_END) pos = shadow_cnt - 1;
        case (mode)
            oase_pkg::MODE_INS_POS, oase_pkg::MODE_INS_FRONT, oase_pkg::MODE_INS_END: begin
                if (shadow_cnt >= 32) st = oase_pkg::ST_FULL;
                else if (pos > shadow_cnt) st = oase_pkg::ST_BAD_POS;
                else begin
                    for (int i = shadow_cnt; i > pos; i--) shadow[i] = shadow[i-1];
                    shadow[pos] = val;
                    shadow_cnt++;
                end
                expected_q.push_back(mk(st, 0, 0, 0, 0, 1));
            end
            oase_pkg::MODE_DEL_POS, oase_pkg::MODE_DEL_FRONT, oase_pkg::MODE_DEL_END: begin
                if (shadow_cnt == 0) st = oase_pkg::ST_EMPTY;
                else if (pos >= shadow_cnt) st = oase_pkg::ST_BAD_POS;
                else begin
                    for (int i = pos; i + 1 < shadow_cnt; i++) shadow[i] = shadow[i+1];
                    shadow_cnt--;
                end
                expected_q.push_back(mk(st, 0, 0, 0, 0, 1));
            end
            oase_pkg::MODE_REVERSE: begin
                for (int i = 0; i < shadow_cnt / 2; i++) begin
                    tmp = shadow[i];
                    shadow[i] = shadow[shadow_cnt-1-i];
                    shadow[shadow_cnt-1-i] = tmp;
                end
                expected_q.push_back(mk(oase_pkg::ST_OK, 0, 0, 0, 0, 1));
            end
            oase_pkg::MODE_SUM: begin
                acc = 0;
                for (int i = 0; i < shadow_cnt; i++) acc += shadow[i];
                expected_q.push_back(mk(oase_pkg::ST_OK, 0, 0, acc, 0, 1));
            end
            oase_pkg::MODE_SEARCH: begin
                hit = -1;
                for (int i = shadow_cnt - 1; i >= 0; i--) if (shadow[i] == val) hit = i;
                if (hit < 0) expected_q.push_back(mk(oase_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1));
                else expected_q.push_back(mk(oase_pkg::ST_OK, 0, hit, 0, 0, 1));
            end
            oase_pkg::MODE_DUMP_FWD, oase_pkg::MODE_DUMP_REV,
            oase_pkg::MODE_DUMP_ODD, oase_pkg::MODE_DUMP_SIGN: begin
                if (shadow_cnt == 0) begin
                    expected_q.push_back(mk(oase_pkg::ST_EMPTY, 0, 0, 0, 0, 1));
                end else if (mode == oase_pkg::MODE_DUMP_FWD) begin
                    for (int i = 0; i < shadow_cnt; i++)
                        expected_q.push_back(mk(oase_pkg::ST_OK, shadow[i], i, 0, 0,
                                                i == shadow_cnt-1));
                end else if (mode == oase_pkg::MODE_DUMP_REV) begin
                    for (int i = shadow_cnt - 1; i >= 0; i--)
                        expected_q.push_back(mk(oase_pkg::ST_OK, shadow[i], i, 0, 0, i == 0));
                end else begin
                    // two passes: even/non-negative group first
                    k = 0;
                    for (int g = 0; g < 2; g++)
                        for (int i = 0; i < shadow_cnt; i++) begin
                            cls = (mode == oase_pkg::MODE_DUMP_ODD) ? shadow[i][0]
                                                                    : shadow[i][31];
                            if (cls == g[0]) begin
                                expected_q.push_back(mk(oase_pkg::ST_OK, shadow[i], i, 0,
                                                        g[0], k == shadow_cnt-1));
                                k++;
                            end
                        end
                end
            end
            default: expected_q.push_back(mk(oase_pkg::ST_OK, 0, 0, 0, 0, 1));
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            shadow_cnt <= 0;
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (expected_q.size() == 0) report("unexpected result", 0, 1);
                else begin
                    want = expected_q.pop_front();
                    if (want.status  !== i_status)  report("status", want.status, i_status);
                    if (want.element !== i_element) report("element", want.element, i_element);
                    if (want.index   !== i_index)   report("index", want.index, i_index);
                    if (want.total   !== i_total)   report("total", want.total, i_total);
                    if (want.count   !== i_count)   report("count", want.count, i_count);
                    if (want.group   !== i_group)   report("group", want.group, i_group);
                    if (want.last    !== i_last)    report("last", want.last, i_last);
                end
            end
            if (i_valid && i_in_ready) begin
                o_commands++;
                predict_command(i_mode, i_value, i_position);
            end
        end
    end

    initial begin
        o_errors   = 0;
        o_commands = 0;
        o_results  = 0;
        shadow_cnt = 0;
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for the ordered array store engine
// Directed corner commands, then random insert/delete-heavy epochs with
// bursty sending and a stalling receiver; results checked by oase_checker.
// ----------------------------------------------------------------------------
module tb;

    localparam int RANDOM_CMDS = 330;
    localparam int IDLE_LIMIT  = 6000;   // cycles with no transaction on either side
    localparam logic [3:0] MODE_SPARE_FIRST = 4'd13;  // codes with no operation
    localparam logic [3:0] MODE_SPARE_LAST  = 4'd15;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [3:0]         i_mode = '0;
    logic signed [31:0] i_value = '0;
    logic [5:0]         i_position = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_element;
    logic [4:0]         o_index;
    logic signed [31:0] o_total;
    logic [5:0]         o_count;
    logic               o_group;
    logic               o_last;

    int errors, pending, commands, results;
    int burst_left;
    int idle_cycles;
    int cyc;

    always #10 i_clk = ~i_clk;

    ordered_array_store_engine dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_value, .i_position,
        .o_valid, .i_ready, .o_status, .o_element, .o_index, .o_total,
        .o_count, .o_group, .o_last
    );

    oase_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_mode, .i_value,
        .i_position, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_status(o_status), .i_element(o_element), .i_index(o_index),
        .i_total(o_total), .i_count(o_count), .i_group(o_group), .i_last(o_last),
        .o_errors(errors), .o_pending(pending), .o_commands(commands),
        .o_results(results)
    );

    // Receiver: phases of always-ready and random stalls, plus one long hold
    // early in the run so the engine backs up and drops o_ready while
    // commands queue.
    initial begin
        int hold;
        hold = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cyc == 600) hold = 400;
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if ((cyc / 700) % 3 == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // Watchdog: any transaction resets the idle counter
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("tb: failure");
            $finish;
        end
    end

    // One transaction on the input channel, followed by a burst gap if due
    task automatic issue(input logic [3:0] mode, input logic [31:0] val, input logic [5:0] pos);
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_value    <= val;
        i_position <= pos;
        do @(posedge i_clk); while (!o_ready);
        if (burst_left > 0) burst_left--;
        else begin
            burst_left = $urandom_range(0, 8);
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7fff_fffc + $urandom_range(0, 3);
            2, 3:    return $urandom_range(0, 9) - 5;   // small pool so searches hit
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [3:0] m;
        int         w;
        cyc = 0;
        idle_cycles = 0;
        burst_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty-array corners, bad positions, extremes, every mode
        issue(oase_pkg::MODE_DUMP_FWD,  0, 0);
        issue(oase_pkg::MODE_DEL_POS,   0, 0);
        issue(oase_pkg::MODE_DEL_FRONT, 0, 0);
        issue(oase_pkg::MODE_DEL_END,   0, 0);
        issue(oase_pkg::MODE_REVERSE,   0, 0);
        issue(oase_pkg::MODE_SUM,       0, 0);
        issue(oase_pkg::MODE_SEARCH,    0, 0);
        issue(oase_pkg::MODE_INS_POS,   5, 1);                 // beyond count
        issue(oase_pkg::MODE_INS_POS,   32'h7fff_ffff, 0);
        issue(oase_pkg::MODE_INS_FRONT, 32'h8000_0000, 0);
        issue(oase_pkg::MODE_INS_END,   32'hffff_ffff, 0);
        issue(oase_pkg::MODE_INS_POS,   32'h0000_0002, 3);     // position equal to count
        issue(oase_pkg::MODE_INS_POS,   32'h1234_5677, 63);
        issue(oase_pkg::MODE_DUMP_ODD,  0, 0);
        issue(oase_pkg::MODE_DUMP_SIGN, 0, 0);
        issue(oase_pkg::MODE_DUMP_REV,  0, 0);
        issue(oase_pkg::MODE_SUM,       0, 0);
        issue(oase_pkg::MODE_SEARCH,    32'hffff_ffff, 0);
        issue(oase_pkg::MODE_SEARCH,    32'h5555_aaaa, 0);
        issue(MODE_SPARE_FIRST, 32'hffff_ffff, 6'h3f);
        issue(MODE_SPARE_LAST, 0, 0);
        issue(oase_pkg::MODE_REVERSE,   0, 0);
        issue(oase_pkg::MODE_DEL_POS,   0, 4);                 // not below count
        issue(oase_pkg::MODE_DEL_POS,   0, 1);
        issue(oase_pkg::MODE_DEL_END,   0, 0);

        // random: alternating fill and drain epochs reach full and empty
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            w = $urandom_range(0, 99);
            if ((n / 60) % 2 == 0) begin
                if (w < 55)
                    m = 4'($urandom_range(oase_pkg::MODE_INS_POS, oase_pkg::MODE_INS_END));
                else if (w < 62)
                    m = 4'($urandom_range(oase_pkg::MODE_DEL_POS, oase_pkg::MODE_DEL_END));
                else
                    m = 4'($urandom_range(oase_pkg::MODE_REVERSE, MODE_SPARE_LAST));
            end else begin
                if (w < 45)
                    m = 4'($urandom_range(oase_pkg::MODE_DEL_POS, oase_pkg::MODE_DEL_END));
                else if (w < 55)
                    m = 4'($urandom_range(oase_pkg::MODE_INS_POS, oase_pkg::MODE_INS_END));
                else
                    m = 4'($urandom_range(oase_pkg::MODE_REVERSE, MODE_SPARE_LAST));
            end
            issue(m, pick_value(),
                  ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 33)));
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("covered %0d commands and %0d results, incl. full, empty and long stall",
                 commands, results);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, pending);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/oase_pkg.sv
rtl/core/oase_cell.sv
rtl/core/ordered_array_store_engine.sv
tb/oase_checker.sv
tb/tb.sv
